/* rtl/vref_pkg.sv */
// Package for the vector refraction pipeline: fixed-point widths, constants
// and the payload structs passed between pipeline sections.
// No dependencies.
`default_nettype none

package vref_pkg;

	// Fixed-point format of all inputs and results
	localparam int FRAC_BITS = 16;
	localparam int IN_W      = 18;
	localparam int ETA_W     = 18;
	localparam int OUT_W     = 21;

	// Intermediate widths, sized to the value ranges of the datapath
	localparam int PROD_W = 2 * IN_W;                 // d_i * n_i
	localparam int DOT_W  = PROD_W + 2;               // sum of three products
	localparam int COS_W  = 21;                       // rounded cosine
	localparam int CN_W   = COS_W + IN_W;             // cos * n_i, plus d_i aligned
	localparam int T_W    = 22;                       // rounded d + cos * n
	localparam int EP_W   = ETA_W + 1 + T_W;          // eta * t
	localparam int PERP_W = 24;                       // perpendicular part
	localparam int MAG_W  = PERP_W - 1;               // |perp_i|
	localparam int SQ_W   = 2 * MAG_W;                // perp_i squared
	localparam int LSQ_W  = 48;                       // |perp|^2 and its distance to 1.0
	localparam int ROOT_W = LSQ_W / 2;                // integer square root
	localparam int REM_W  = ROOT_W + 2;               // square root remainder
	localparam int PN_W   = ROOT_W + 1 + IN_W;        // root * n_i
	localparam int PAR_W  = PN_W - FRAC_BITS;         // rounded parallel part
	localparam int SUM_W  = PAR_W + 1;                // perp + par before clamp

	// Square root digit recurrence: two radicand bits per step
	localparam int SQRT_STEPS  = 4;
	localparam int SQRT_STAGES = ROOT_W / SQRT_STEPS;

	// 1.0 with doubled fraction bits, and the rounding half
	localparam longint ONE_WIDE = longint'(1) << (2 * FRAC_BITS);
	localparam longint HALF_LSB = longint'(1) << (FRAC_BITS - 1);
	localparam longint OUT_HI   = (longint'(1) << (OUT_W - 1)) - 1;
	localparam longint OUT_LO   = -(longint'(1) << (OUT_W - 1));

	typedef logic signed [IN_W-1:0] coord_t;

	// One accepted input item
	typedef struct packed {
		logic [2:0][IN_W-1:0] dir;
		logic [2:0][IN_W-1:0] norm;
		logic [ETA_W-1:0]     eta;
	} hit_t;

	// Front section result: perpendicular part and root argument
	typedef struct packed {
		logic [2:0][PERP_W-1:0] perp;
		logic [2:0][IN_W-1:0]   norm;
		logic [LSQ_W-1:0]       diff;
	} front_t;

	// One square root stage: radicand bits left, remainder, partial root
	typedef struct packed {
		logic [2:0][PERP_W-1:0] perp;
		logic [2:0][IN_W-1:0]   norm;
		logic [LSQ_W-1:0]       rad;
		logic [REM_W-1:0]       rem;
		logic [ROOT_W-1:0]      root;
	} sqrt_st_t;

	// Square root section result
	typedef struct packed {
		logic [2:0][PERP_W-1:0] perp;
		logic [2:0][IN_W-1:0]   norm;
		logic [ROOT_W-1:0]      root;
	} root_t;

	// One result item
	typedef struct packed {
		logic [2:0][OUT_W-1:0] vec;
	} ray_t;

endpackage

`default_nettype wire

/* rtl/vref_in_if.sv */
// Input channel of the vector refraction block: valid/ready plus one hit item.
// Depends on vref_pkg.
`default_nettype none

interface vref_in_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [vref_pkg::IN_W-1:0]      dir_x;
	logic signed [vref_pkg::IN_W-1:0]      dir_y;
	logic signed [vref_pkg::IN_W-1:0]      dir_z;
	logic signed [vref_pkg::IN_W-1:0]      norm_x;
	logic signed [vref_pkg::IN_W-1:0]      norm_y;
	logic signed [vref_pkg::IN_W-1:0]      norm_z;
	logic        [vref_pkg::ETA_W-1:0]     eta_ratio;

	modport source (
		output valid, dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, eta_ratio,
		input  ready
	);
	modport sink (
		input  valid, dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, eta_ratio,
		output ready
	);
endinterface

`default_nettype wire

/* rtl/vref_out_if.sv */
// Output channel of the vector refraction block: valid/ready plus one ray item.
// Depends on vref_pkg.
`default_nettype none

interface vref_out_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [vref_pkg::OUT_W-1:0]     out_x;
	logic signed [vref_pkg::OUT_W-1:0]     out_y;
	logic signed [vref_pkg::OUT_W-1:0]     out_z;

	modport source (
		output valid, out_x, out_y, out_z,
		input  ready
	);
	modport sink (
		input  valid, out_x, out_y, out_z,
		output ready
	);
endinterface

`default_nettype wire

/* rtl/vref_front.sv */
// Front section, eight stages: cosine, perpendicular part, |perp|^2 and
// its distance to 1.0. Depends on vref_pkg.
`default_nettype none

module vref_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  vref_pkg::hit_t  in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output vref_pkg::front_t out_data
);
	import vref_pkg::*;

	localparam int NST = 8;

	localparam logic signed [DOT_W-1:0] ONE_DOT  = DOT_W'(ONE_WIDE);
	localparam logic signed [DOT_W-1:0] HALF_DOT = DOT_W'(HALF_LSB);
	localparam logic signed [CN_W-1:0]  HALF_CN  = CN_W'(HALF_LSB);
	localparam logic signed [EP_W-1:0]  HALF_EP  = EP_W'(HALF_LSB);
	localparam logic [LSQ_W-1:0]        ONE_LSQ  = LSQ_W'(ONE_WIDE);

	logic [NST-1:0] vld_q;
	logic [NST-1:0] adv;

	// Stage registers
	logic signed [PROD_W-1:0] prod_s1 [3];
	coord_t                   d_s1 [3], d_s2 [3], d_s3 [3];
	coord_t                   n_s1 [3], n_s2 [3], n_s3 [3], n_s4 [3];
	coord_t                   n_s5 [3], n_s6 [3], n_s7 [3], n_s8 [3];
	logic [ETA_W-1:0]         eta_s1, eta_s2, eta_s3, eta_s4;
	logic signed [COS_W-1:0]  cos_s2;
	logic signed [CN_W-1:0]   cn_s3 [3];
	logic signed [T_W-1:0]    t_s4 [3];
	logic signed [EP_W-1:0]   ep_s5 [3];
	logic signed [PERP_W-1:0] perp_s6 [3], perp_s7 [3], perp_s8 [3];
	logic [SQ_W-1:0]          sq_s7 [3];
	logic [LSQ_W-1:0]         diff_s8;

	// Combinational parts
	logic signed [DOT_W-1:0]  dot_sum, neg_dot, nd_clip, nd_rnd;
	logic signed [CN_W-1:0]   t_sum [3];
	logic signed [EP_W-1:0]   ep_rnd [3];
	logic signed [PERP_W-1:0] perp_neg [3];
	logic [MAG_W-1:0]         mag [3];
	logic [LSQ_W-1:0]         lsq;

	// A stage advances when it is empty or the next one advances
	always_comb begin
		adv[NST-1] = ~vld_q[NST-1] | out_ready;
		for (int k = NST - 2; k >= 0; k--) begin
			adv[k] = ~vld_q[k] | adv[k+1];
		end
	end

	assign in_ready  = adv[0];
	assign out_valid = vld_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NST; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// Negated dot product, clipped at 1.0, then rounded
	always_comb begin
		dot_sum = DOT_W'(prod_s1[0]) + DOT_W'(prod_s1[1]) + DOT_W'(prod_s1[2]);
		neg_dot = -dot_sum;
		nd_clip = (neg_dot > ONE_DOT) ? ONE_DOT : neg_dot;
		nd_rnd  = nd_clip + HALF_DOT;
	end

	// Per-lane rounding and magnitude
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			t_sum[i]    = (CN_W'(d_s3[i]) <<< FRAC_BITS) + cn_s3[i] + HALF_CN;
			ep_rnd[i]   = ep_s5[i] + HALF_EP;
			perp_neg[i] = -perp_s6[i];
			mag[i]      = perp_s6[i][PERP_W-1] ? perp_neg[i][MAG_W-1:0]
			                                   : perp_s6[i][MAG_W-1:0];
		end
	end

	// Squared length and its distance to 1.0
	always_comb begin
		lsq = LSQ_W'(sq_s7[0]) + LSQ_W'(sq_s7[1]) + LSQ_W'(sq_s7[2]);
	end

	// Datapath registers, each loaded when its stage advances
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			for (int i = 0; i < 3; i++) begin
				prod_s1[i] <= $signed(in_data.dir[i]) * $signed(in_data.norm[i]);
				d_s1[i]    <= $signed(in_data.dir[i]);
				n_s1[i]    <= $signed(in_data.norm[i]);
			end
			eta_s1 <= in_data.eta;
		end
		if (adv[1]) begin
			cos_s2 <= $signed(nd_rnd[FRAC_BITS +: COS_W]);
			d_s2   <= d_s1;
			n_s2   <= n_s1;
			eta_s2 <= eta_s1;
		end
		if (adv[2]) begin
			for (int i = 0; i < 3; i++) begin
				cn_s3[i] <= cos_s2 * n_s2[i];
			end
			d_s3   <= d_s2;
			n_s3   <= n_s2;
			eta_s3 <= eta_s2;
		end
		if (adv[3]) begin
			for (int i = 0; i < 3; i++) begin
				t_s4[i] <= $signed(t_sum[i][FRAC_BITS +: T_W]);
			end
			n_s4   <= n_s3;
			eta_s4 <= eta_s3;
		end
		if (adv[4]) begin
			for (int i = 0; i < 3; i++) begin
				ep_s5[i] <= $signed({1'b0, eta_s4}) * t_s4[i];
			end
			n_s5 <= n_s4;
		end
		if (adv[5]) begin
			for (int i = 0; i < 3; i++) begin
				perp_s6[i] <= $signed(ep_rnd[i][FRAC_BITS +: PERP_W]);
			end
			n_s6 <= n_s5;
		end
		if (adv[6]) begin
			for (int i = 0; i < 3; i++) begin
				sq_s7[i] <= mag[i] * mag[i];
			end
			perp_s7 <= perp_s6;
			n_s7    <= n_s6;
		end
		if (adv[7]) begin
			diff_s8 <= (lsq >= ONE_LSQ) ? (lsq - ONE_LSQ) : (ONE_LSQ - lsq);
			perp_s8 <= perp_s7;
			n_s8    <= n_s7;
		end
	end

	// Pack the section result
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			out_data.perp[i] = perp_s8[i];
			out_data.norm[i] = n_s8[i];
		end
		out_data.diff = diff_s8;
	end

endmodule

`default_nettype wire

/* rtl/vref_sqrt.sv */
// Integer square root section: digit recurrence, SQRT_STEPS result bits per
// stage over SQRT_STAGES stages. Depends on vref_pkg.
`default_nettype none

module vref_sqrt (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  vref_pkg::front_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output vref_pkg::root_t  out_data
);
	import vref_pkg::*;

	localparam int NST = SQRT_STAGES;

	logic [NST-1:0] vld_q;
	logic [NST-1:0] adv;
	sqrt_st_t       pipe_s [NST];
	sqrt_st_t       nxt    [NST];
	sqrt_st_t       init;

	// A stage advances when it is empty or the next one advances
	always_comb begin
		adv[NST-1] = ~vld_q[NST-1] | out_ready;
		for (int k = NST - 2; k >= 0; k--) begin
			adv[k] = ~vld_q[k] | adv[k+1];
		end
	end

	assign in_ready  = adv[0];
	assign out_valid = vld_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NST; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// Start with the full radicand, empty remainder and root
	always_comb begin
		init.perp = in_data.perp;
		init.norm = in_data.norm;
		init.rad  = in_data.diff;
		init.rem  = '0;
		init.root = '0;
	end

	for (genvar g = 0; g < NST; g++) begin : g_stage
		sqrt_st_t src;

		if (g == 0) begin : g_first
			assign src = init;
		end else begin : g_next
			assign src = pipe_s[g-1];
		end

		// Restoring steps: bring down two bits, try subtracting 4*root+1
		always_comb begin : step_c
			logic [REM_W+1:0] acc;
			logic [REM_W+1:0] trial;
			nxt[g] = src;
			for (int k = 0; k < SQRT_STEPS; k++) begin
				acc   = {nxt[g].rem, nxt[g].rad[LSQ_W-1 -: 2]};
				trial = (REM_W + 2)'({nxt[g].root, 2'b01});
				if (acc >= trial) begin
					nxt[g].rem  = REM_W'(acc - trial);
					nxt[g].root = {nxt[g].root[ROOT_W-2:0], 1'b1};
				end else begin
					nxt[g].rem  = acc[REM_W-1:0];
					nxt[g].root = {nxt[g].root[ROOT_W-2:0], 1'b0};
				end
				nxt[g].rad = {nxt[g].rad[LSQ_W-3:0], 2'b00};
			end
		end

		always_ff @(posedge clk) begin
			if (adv[g]) begin
				pipe_s[g] <= nxt[g];
			end
		end
	end

	assign out_data.perp = pipe_s[NST-1].perp;
	assign out_data.norm = pipe_s[NST-1].norm;
	assign out_data.root = pipe_s[NST-1].root;

endmodule

`default_nettype wire

/* rtl/vref_back.sv */
// Back section, two stages: parallel part -root*n, sum with the
// perpendicular part and saturation to the output width. Depends on vref_pkg.
`default_nettype none

module vref_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  vref_pkg::root_t in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output vref_pkg::ray_t  out_data
);
	import vref_pkg::*;

	localparam int NST = 2;

	localparam logic signed [PN_W-1:0]  HALF_PN = PN_W'(HALF_LSB);
	localparam logic signed [SUM_W-1:0] SAT_HI  = SUM_W'(OUT_HI);
	localparam logic signed [SUM_W-1:0] SAT_LO  = SUM_W'(OUT_LO);

	logic [NST-1:0] vld_q;
	logic [NST-1:0] adv;

	logic signed [PN_W-1:0]   pn_s1 [3];
	logic signed [PERP_W-1:0] perp_s1 [3];
	logic [OUT_W-1:0]         res_s2 [3];

	logic signed [PN_W-1:0]   pn_rnd [3];
	logic signed [PAR_W-1:0]  par [3];
	logic signed [SUM_W-1:0]  sum [3];
	logic [OUT_W-1:0]         sat [3];

	// A stage advances when it is empty or the next one advances
	always_comb begin
		adv[NST-1] = ~vld_q[NST-1] | out_ready;
		for (int k = NST - 2; k >= 0; k--) begin
			adv[k] = ~vld_q[k] | adv[k+1];
		end
	end

	assign in_ready  = adv[0];
	assign out_valid = vld_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NST; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// Round the negated product, add, saturate
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pn_rnd[i] = -pn_s1[i] + HALF_PN;
			par[i]    = $signed(pn_rnd[i][FRAC_BITS +: PAR_W]);
			sum[i]    = SUM_W'(perp_s1[i]) + SUM_W'(par[i]);
			if (sum[i] > SAT_HI) begin
				sat[i] = SAT_HI[OUT_W-1:0];
			end else if (sum[i] < SAT_LO) begin
				sat[i] = SAT_LO[OUT_W-1:0];
			end else begin
				sat[i] = sum[i][OUT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			for (int i = 0; i < 3; i++) begin
				pn_s1[i]   <= $signed({1'b0, in_data.root}) * $signed(in_data.norm[i]);
				perp_s1[i] <= $signed(in_data.perp[i]);
			end
		end
		if (adv[1]) begin
			res_s2 <= sat;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			out_data.vec[i] = res_s2[i];
		end
	end

endmodule

`default_nettype wire

/* rtl/vector_refraction_top.sv */
// Top level of the vector refraction block: front, square root and back
// sections in one valid/ready pipeline. Depends on vref_pkg, vref_in_if,
// vref_out_if, vref_front, vref_sqrt, vref_back.
//
//   Port   Dir   Item                                   Handshake
//   hit    in    dir_x/y/z, norm_x/y/z, eta_ratio       valid & ready
//   ray    out   out_x/y/z                              valid & ready
//
// The pipeline has 8 front stages, 6 square root stages (4 root bits
// each) and 2 back stages. One item enters per cycle when nothing stalls.
// Reset clears only the valid bits of every stage.
// Each stage holds while it is full and the stage after it cannot take its
// item; empty stages keep filling, so hit.ready stays high until all are full.
`default_nettype none

module vector_refraction_top (
	input  logic        clk,
	input  logic        arst_n,
	vref_in_if.sink     hit,
	vref_out_if.source  ray
);
	import vref_pkg::*;

	hit_t   hit_d;
	front_t front_d;
	root_t  root_d;
	ray_t   ray_d;
	logic   front_vld, front_rdy;
	logic   root_vld, root_rdy;

	// Gather the input item
	assign hit_d.dir  = {hit.dir_z, hit.dir_y, hit.dir_x};
	assign hit_d.norm = {hit.norm_z, hit.norm_y, hit.norm_x};
	assign hit_d.eta  = hit.eta_ratio;

	vref_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (hit.valid),
		.in_ready  (hit.ready),
		.in_data   (hit_d),
		.out_valid (front_vld),
		.out_ready (front_rdy),
		.out_data  (front_d)
	);

	vref_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_vld),
		.in_ready  (front_rdy),
		.in_data   (front_d),
		.out_valid (root_vld),
		.out_ready (root_rdy),
		.out_data  (root_d)
	);

	vref_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (root_vld),
		.in_ready  (root_rdy),
		.in_data   (root_d),
		.out_valid (ray.valid),
		.out_ready (ray.ready),
		.out_data  (ray_d)
	);

	// Spread the result item
	assign ray.out_x = $signed(ray_d.vec[0]);
	assign ray.out_y = $signed(ray_d.vec[1]);
	assign ray.out_z = $signed(ray_d.vec[2]);

endmodule

`default_nettype wire
